>>> rtl/state_variable_filter_2pole_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-pole state-variable filter
// Clocked on i_clk; the checking form is masked while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STATE_VARIABLE_FILTER_2POLE_UNIT_ASSERT_SVH
`define STATE_VARIABLE_FILTER_2POLE_UNIT_ASSERT_SVH

// checked only out of reset
`define SVF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define SVF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> rtl/svf2p_pkg.sv
// ----------------------------------------------------------------------------
// svf2p_pkg
// Shared constants, control word and microprogram of the two-pole SVF.
// ----------------------------------------------------------------------------
`default_nettype none

package svf2p_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 20;
    localparam int COEF_INT_BITS      = 4;
    localparam int STATE_BITS         = 40;
    localparam int STATE_HALF         = STATE_BITS / 2;
    localparam int BLEND_FRAC         = 20;
    localparam int BLEND_BITS         = BLEND_FRAC + 1;
    localparam int FTYPE_BITS         = 3;
    localparam int FT_BYPASS_BIT      = 2;
    localparam int CFG_IDX_BITS       = 3;
    localparam int STEP_BITS          = 5;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FILTER_TYPE  = 3'd0,
        REG_GAIN_NORM    = 3'd1,
        REG_WARPED_GAIN  = 3'd2,
        REG_DAMPING_SUM  = 3'd3,
        REG_BLEND_WEIGHT = 3'd4
    } t_reg;

    // codes 4..7 are bypass (top bit set)
    typedef enum logic [FTYPE_BITS-1:0] {
        FT_LPF = 3'd0,
        FT_HPF = 3'd1,
        FT_BPF = 3'd2,
        FT_BSF = 3'd3
    } t_ftype;

    typedef enum logic [1:0] {A_Z1, A_HPF, A_BPF, A_LPF} t_asel;
    typedef enum logic [2:0] {C_RHO, C_ALPHA, C_G, C_W, C_WC} t_csel;
    typedef enum logic [1:0] {ACC_NOP, ACC_LOAD, ACC_ADD} t_acc;
    typedef enum logic [1:0] {R_T, R_GH, R_GB} t_rdst;
    typedef enum logic [2:0] {
        D_NONE, D_T, D_HPF, D_BPF, D_LPF, D_BSF, D_Z1, D_Z2
    } t_dst;
    typedef enum logic [1:0] {P_X, P_T, P_GH, P_GB} t_psel;
    typedef enum logic [2:0] {Q_ZERO, Q_T, Q_Z1, Q_Z2, Q_BPF, Q_LPF} t_qsel;
    typedef enum logic [1:0] {J_NEXT, J_IF_BYPASS, J_IF_NOT_BLEND, J_END} t_jmp;

    typedef struct packed {
        logic                 mul_en;
        t_asel                mul_a;
        t_csel                mul_c;
        logic                 mul_hi;
        t_acc                 acc_op;
        logic                 rnd_en;
        logic                 rnd_blend;
        t_rdst                rnd_dst;
        t_dst                 alu_dst;
        t_psel                alu_p;
        t_qsel                alu_q;
        logic                 alu_sub;
        t_jmp                 jmp;
        logic [STEP_BITS-1:0] target;
    } t_uop;

    typedef struct packed {
        logic bypass;
        logic blend;
    } t_stat;

    localparam logic [STEP_BITS-1:0] S_OUT = 5'd30;

    localparam t_uop UOP_NOP = '{
        mul_en: 1'b0, mul_a: A_Z1, mul_c: C_RHO, mul_hi: 1'b0,
        acc_op: ACC_NOP, rnd_en: 1'b0, rnd_blend: 1'b0, rnd_dst: R_T,
        alu_dst: D_NONE, alu_p: P_X, alu_q: Q_ZERO, alu_sub: 1'b0,
        jmp: J_NEXT, target: '0
    };

    // Each coefficient product is two passes of a half-width multiply
    // (low half, high half), accumulated, then rounded and shifted.
    function automatic t_uop uop_rom(input logic [STEP_BITS-1:0] step);
        t_uop u;
        u = UOP_NOP;
        case (step)
            // rho * z1
            5'd0: begin
                u.mul_en = 1'b1; u.mul_a = A_Z1; u.mul_c = C_RHO;
                u.jmp = J_IF_BYPASS; u.target = S_OUT;
            end
            5'd1: begin
                u.mul_en = 1'b1; u.mul_a = A_Z1; u.mul_c = C_RHO; u.mul_hi = 1'b1;
                u.acc_op = ACC_LOAD;
            end
            5'd2: u.acc_op = ACC_ADD;
            5'd3: begin
                u.rnd_en = 1'b1; u.rnd_dst = R_T;
            end
            5'd4: begin
                u.alu_dst = D_T; u.alu_p = P_X; u.alu_q = Q_T; u.alu_sub = 1'b1;
            end
            5'd5: begin
                u.alu_dst = D_HPF; u.alu_p = P_T; u.alu_q = Q_Z2; u.alu_sub = 1'b1;
            end
            // alpha0 * (x - rho*z1 - z2)
            5'd6: begin
                u.mul_en = 1'b1; u.mul_a = A_HPF; u.mul_c = C_ALPHA;
            end
            5'd7: begin
                u.mul_en = 1'b1; u.mul_a = A_HPF; u.mul_c = C_ALPHA; u.mul_hi = 1'b1;
                u.acc_op = ACC_LOAD;
            end
            5'd8: u.acc_op = ACC_ADD;
            5'd9: begin
                u.rnd_en = 1'b1; u.rnd_dst = R_T;
            end
            5'd10: begin
                u.alu_dst = D_HPF; u.alu_p = P_T; u.alu_q = Q_ZERO;
            end
            // g * hpf
            5'd11: begin
                u.mul_en = 1'b1; u.mul_a = A_HPF; u.mul_c = C_G;
            end
            5'd12: begin
                u.mul_en = 1'b1; u.mul_a = A_HPF; u.mul_c = C_G; u.mul_hi = 1'b1;
                u.acc_op = ACC_LOAD;
            end
            5'd13: u.acc_op = ACC_ADD;
            5'd14: begin
                u.rnd_en = 1'b1; u.rnd_dst = R_GH;
            end
            5'd15: begin
                u.alu_dst = D_BPF; u.alu_p = P_GH; u.alu_q = Q_Z1;
            end
            // g * bpf
            5'd16: begin
                u.mul_en = 1'b1; u.mul_a = A_BPF; u.mul_c = C_G;
            end
            5'd17: begin
                u.mul_en = 1'b1; u.mul_a = A_BPF; u.mul_c = C_G; u.mul_hi = 1'b1;
                u.acc_op = ACC_LOAD;
            end
            5'd18: u.acc_op = ACC_ADD;
            5'd19: begin
                u.rnd_en = 1'b1; u.rnd_dst = R_GB;
            end
            5'd20: begin
                u.alu_dst = D_LPF; u.alu_p = P_GB; u.alu_q = Q_Z2;
            end
            5'd21: begin
                u.alu_dst = D_Z1; u.alu_p = P_GH; u.alu_q = Q_BPF;
            end
            5'd22: begin
                u.alu_dst = D_Z2; u.alu_p = P_GB; u.alu_q = Q_LPF;
                u.jmp = J_IF_NOT_BLEND; u.target = S_OUT;
            end
            // w*hpf + (one-w)*lpf
            5'd23: begin
                u.mul_en = 1'b1; u.mul_a = A_HPF; u.mul_c = C_W;
            end
            5'd24: begin
                u.mul_en = 1'b1; u.mul_a = A_HPF; u.mul_c = C_W; u.mul_hi = 1'b1;
                u.acc_op = ACC_LOAD;
            end
            5'd25: begin
                u.mul_en = 1'b1; u.mul_a = A_LPF; u.mul_c = C_WC;
                u.acc_op = ACC_ADD;
            end
            5'd26: begin
                u.mul_en = 1'b1; u.mul_a = A_LPF; u.mul_c = C_WC; u.mul_hi = 1'b1;
                u.acc_op = ACC_ADD;
            end
            5'd27: u.acc_op = ACC_ADD;
            5'd28: begin
                u.rnd_en = 1'b1; u.rnd_blend = 1'b1; u.rnd_dst = R_T;
            end
            5'd29: begin
                u.alu_dst = D_BSF; u.alu_p = P_T; u.alu_q = Q_ZERO;
            end
            5'd30: u.jmp = J_END;
            default: u.jmp = J_END;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

>>> rtl/svf2p_if.sv
// ----------------------------------------------------------------------------
// svf2p channel interfaces
// Sample in, result out and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
`default_nettype none

interface svf2p_in_if #(
    parameter int SAMPLE_BITS = svf2p_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface svf2p_out_if #(
    parameter int SAMPLE_BITS = svf2p_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface svf2p_cfg_if #(
    parameter int DATA_BITS = svf2p_pkg::COEF_FRAC_BITS_DEF + svf2p_pkg::COEF_INT_BITS
);
    logic                                  valid;
    logic                                  ready;
    logic [svf2p_pkg::CFG_IDX_BITS-1:0]    index;
    logic [DATA_BITS-1:0]                  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/state_variable_filter_2pole_unit.sv
// ----------------------------------------------------------------------------
// state_variable_filter_2pole_unit
// Two-pole zero-delay state-variable filter with microcoded control.
// ----------------------------------------------------------------------------
// One sample in, one saturated sample out. A sample is taken when the unit is
// idle; the microprogram then runs (bypass types jump to its end, the blended
// band-stop also runs the blend steps) and at its end loads the result into
// the output register; the unit is ready for the next sample in the cycle
// after that load. The single 21 x 25-bit multiplier is shared: every
// coefficient product takes two passes through it plus an accumulate, round
// and saturate step, all issued by a 31-word microprogram. The output
// register lets a new sample enter while the last result waits. Registers are
// written over the always-ready config channel; the user must write them only
// while no sample is in flight, and the unit does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "state_variable_filter_2pole_unit_assert.svh"

module state_variable_filter_2pole_unit #(
    parameter int SAMPLE_BITS    = svf2p_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = svf2p_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    svf2p_in_if.sink    i_in,
    svf2p_out_if.source o_out,
    svf2p_cfg_if.sink   i_cfg
);

    localparam int SB = SAMPLE_BITS;
    localparam logic signed [SB-1:0] Y_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] Y_MIN = {1'b1, {(SB-1){1'b0}}};

    svf2p_pkg::t_uop uop_word, dp_uop;
    svf2p_pkg::t_stat dp_stat;

    logic [svf2p_pkg::STEP_BITS-1:0] r_step, n_step;
    logic                            r_busy, n_busy;
    logic                            r_out_valid, n_out_valid;
    logic signed [SB-1:0]            r_out_sample;
    logic                            r_out_clip;
    logic                            in_xfer, out_load;
    logic signed [SB-1:0]            dp_y;
    logic                            dp_clip;

    assign i_in.ready  = !r_busy;
    assign in_xfer     = i_in.valid && !r_busy;
    assign i_cfg.ready = 1'b1;

    assign uop_word = svf2p_pkg::uop_rom(r_step);
    assign dp_uop   = r_busy ? uop_word : svf2p_pkg::UOP_NOP;

    // sequencer: step counter with conditional jumps
    always_comb begin
        n_step   = r_step + 1'b1;
        n_busy   = r_busy;
        out_load = 1'b0;
        if (!r_busy) begin
            n_step = r_step;
            if (in_xfer) begin
                n_busy = 1'b1;
                n_step = '0;
            end
        end else begin
            case (uop_word.jmp)
                svf2p_pkg::J_IF_BYPASS: begin
                    if (dp_stat.bypass) begin
                        n_step = uop_word.target;
                    end
                end
                svf2p_pkg::J_IF_NOT_BLEND: begin
                    if (!dp_stat.blend) begin
                        n_step = uop_word.target;
                    end
                end
                svf2p_pkg::J_END: begin
                    // hold here until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        out_load = 1'b1;
                        n_busy   = 1'b0;
                        n_step   = '0;
                    end else begin
                        n_step = r_step;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sample <= dp_y;
            r_out_clip   <= dp_clip;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.clipped    = r_out_clip;

    svf2p_dp #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_xfer),
        .i_sample   (i_in.sample_in),
        .i_uop      (dp_uop),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_idx  (i_cfg.index),
        .i_cfg_data (i_cfg.data),
        .o_stat     (dp_stat),
        .o_y        (dp_y),
        .o_clip     (dp_clip)
    );

    `SVF_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!r_busy && !r_out_valid), "reset left unit busy")
    `SVF_ASSERT(a_accept_starts, in_xfer |=> (r_busy && r_step == '0), "transfer did not start program")
    `SVF_ASSERT(a_step_range, r_busy |-> (r_step <= svf2p_pkg::S_OUT), "step past end of program")
    `SVF_ASSERT(a_load_frees, out_load |=> (!r_busy && r_out_valid), "result load did not free unit")
    `SVF_ASSERT(a_clip_at_rail, (r_out_valid && r_out_clip) |-> (r_out_sample == Y_MAX || r_out_sample == Y_MIN), "clip flag off rail")

endmodule

`default_nettype wire

>>> rtl/svf2p_dp.sv
// ----------------------------------------------------------------------------
// svf2p_dp
// Register file, shared half-width multiplier, accumulator, rounding shifter
// and saturating adder, all steered by one control word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module svf2p_dp #(
    parameter int  SAMPLE_BITS    = svf2p_pkg::SAMPLE_BITS_DEF,
    parameter int  COEF_FRAC_BITS = svf2p_pkg::COEF_FRAC_BITS_DEF,
    localparam int CW             = COEF_FRAC_BITS + svf2p_pkg::COEF_INT_BITS,
    localparam int BW             = svf2p_pkg::BLEND_BITS,
    localparam int MC             = (CW > BW) ? CW : BW
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_load,
    input  wire  logic signed [SAMPLE_BITS-1:0]  i_sample,
    input  wire  svf2p_pkg::t_uop                i_uop,
    input  wire                                  i_cfg_we,
    input  wire  [svf2p_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire  [MC-1:0]                        i_cfg_data,
    output svf2p_pkg::t_stat                     o_stat,
    output logic signed [SAMPLE_BITS-1:0]        o_y,
    output logic                                 o_clip
);

    localparam int SB  = SAMPLE_BITS;
    localparam int SW  = svf2p_pkg::STATE_BITS;
    localparam int H   = svf2p_pkg::STATE_HALF;
    localparam int BF  = svf2p_pkg::BLEND_FRAC;
    localparam int PRW = H + MC + 2;
    localparam int AW  = SW + MC + 2;
    localparam int TW  = SW + MC - COEF_FRAC_BITS + 2;
    localparam int TW1 = TW + 1;

    localparam logic [CW-1:0] COEF_ONE =
        {{(CW-COEF_FRAC_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};
    localparam logic [BW-1:0] W_ONE  = {1'b1, {BF{1'b0}}};
    localparam logic [BW-1:0] W_HALF = {1'b0, 1'b1, {(BF-1){1'b0}}};
    localparam logic signed [AW-1:0] RC_HALF =
        {{(AW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [AW-1:0] RB_HALF = {{(AW-BF){1'b0}}, 1'b1, {(BF-1){1'b0}}};
    localparam logic signed [TW:0] S_MAX = {{(TW-SW+2){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [TW:0] S_MIN = {{(TW-SW+2){1'b1}}, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] Y_MAX = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [SW-1:0] Y_MIN = {{(SW-SB+1){1'b1}}, {(SB-1){1'b0}}};

    logic [svf2p_pkg::FTYPE_BITS-1:0] r_ftype;
    logic [CW-1:0]                    r_alpha, r_g, r_rho;
    logic [BW-1:0]                    r_w;

    logic signed [SB-1:0]  r_x;
    logic signed [SW-1:0]  r_z1, r_z2, r_hpf, r_bpf, r_lpf, r_bsf;
    logic signed [TW-1:0]  r_t, r_gh, r_gb;
    logic signed [PRW-1:0] r_prod;
    logic                  r_prod_hi;
    logic signed [AW-1:0]  r_acc;

    logic [BW-1:0]         w_clamp, w_rest;
    logic signed [SW-1:0]  mul_src;
    logic [MC-1:0]         mul_coef;
    logic signed [H:0]     m_a;
    logic signed [MC:0]    m_c;
    logic signed [PRW-1:0] n_prod;
    logic signed [AW-1:0]  acc_part;
    logic signed [AW-1:0]  rnd_sum, rnd_c, rnd_b;
    logic signed [TW-1:0]  rnd_val;
    logic signed [TW-1:0]  p_val, q_val;
    logic signed [TW:0]    alu_sum;
    logic signed [SW-1:0]  alu_sat;
    logic signed [SW-1:0]  y_src;

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ftype <= svf2p_pkg::FT_LPF;
            r_alpha <= COEF_ONE;
            r_g     <= COEF_ONE;
            r_rho   <= COEF_ONE;
            r_w     <= W_HALF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                svf2p_pkg::REG_FILTER_TYPE:  r_ftype <= i_cfg_data[svf2p_pkg::FTYPE_BITS-1:0];
                svf2p_pkg::REG_GAIN_NORM:    r_alpha <= i_cfg_data[CW-1:0];
                svf2p_pkg::REG_WARPED_GAIN:  r_g     <= i_cfg_data[CW-1:0];
                svf2p_pkg::REG_DAMPING_SUM:  r_rho   <= i_cfg_data[CW-1:0];
                svf2p_pkg::REG_BLEND_WEIGHT: r_w     <= i_cfg_data[BW-1:0];
                default: ;
            endcase
        end
    end

    // weights above one count as one
    assign w_clamp = (r_w > W_ONE) ? W_ONE : r_w;
    assign w_rest  = W_ONE - w_clamp;

    // ---------------- multiplier ----------------
    always_comb begin
        case (i_uop.mul_a)
            svf2p_pkg::A_Z1:  mul_src = r_z1;
            svf2p_pkg::A_HPF: mul_src = r_hpf;
            svf2p_pkg::A_BPF: mul_src = r_bpf;
            svf2p_pkg::A_LPF: mul_src = r_lpf;
            default:          mul_src = r_z1;
        endcase
        case (i_uop.mul_c)
            svf2p_pkg::C_RHO:   mul_coef = MC'(r_rho);
            svf2p_pkg::C_ALPHA: mul_coef = MC'(r_alpha);
            svf2p_pkg::C_G:     mul_coef = MC'(r_g);
            svf2p_pkg::C_W:     mul_coef = MC'(w_clamp);
            svf2p_pkg::C_WC:    mul_coef = MC'(w_rest);
            default:            mul_coef = '0;
        endcase
        // low half is unsigned, high half carries the sign
        if (i_uop.mul_hi) begin
            m_a = {mul_src[SW-1], mul_src[SW-1:H]};
        end else begin
            m_a = {1'b0, mul_src[H-1:0]};
        end
        m_c = {1'b0, mul_coef};
    end

    assign n_prod   = m_a * m_c;
    assign acc_part = r_prod_hi ? {r_prod, {H{1'b0}}} : {{H{r_prod[PRW-1]}}, r_prod};

    // ---------------- round half up, floor shift ----------------
    always_comb begin
        rnd_sum = r_acc + (i_uop.rnd_blend ? RB_HALF : RC_HALF);
        rnd_c   = rnd_sum >>> COEF_FRAC_BITS;
        rnd_b   = rnd_sum >>> BF;
        rnd_val = i_uop.rnd_blend ? rnd_b[TW-1:0] : rnd_c[TW-1:0];
    end

    // ---------------- saturating adder ----------------
    always_comb begin
        case (i_uop.alu_p)
            svf2p_pkg::P_X:  p_val = TW'(r_x);
            svf2p_pkg::P_T:  p_val = r_t;
            svf2p_pkg::P_GH: p_val = r_gh;
            svf2p_pkg::P_GB: p_val = r_gb;
            default:         p_val = r_t;
        endcase
        case (i_uop.alu_q)
            svf2p_pkg::Q_ZERO: q_val = '0;
            svf2p_pkg::Q_T:    q_val = r_t;
            svf2p_pkg::Q_Z1:   q_val = TW'(r_z1);
            svf2p_pkg::Q_Z2:   q_val = TW'(r_z2);
            svf2p_pkg::Q_BPF:  q_val = TW'(r_bpf);
            svf2p_pkg::Q_LPF:  q_val = TW'(r_lpf);
            default:           q_val = '0;
        endcase
        if (i_uop.alu_sub) begin
            alu_sum = TW1'(p_val) - TW1'(q_val);
        end else begin
            alu_sum = TW1'(p_val) + TW1'(q_val);
        end
        if (alu_sum > S_MAX) begin
            alu_sat = S_MAX[SW-1:0];
        end else if (alu_sum < S_MIN) begin
            alu_sat = S_MIN[SW-1:0];
        end else begin
            alu_sat = alu_sum[SW-1:0];
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_sample;
        end
        if (i_uop.mul_en) begin
            r_prod    <= n_prod;
            r_prod_hi <= i_uop.mul_hi;
        end
        case (i_uop.acc_op)
            svf2p_pkg::ACC_LOAD: r_acc <= acc_part;
            svf2p_pkg::ACC_ADD:  r_acc <= r_acc + acc_part;
            default: ;
        endcase
        if (i_uop.rnd_en) begin
            case (i_uop.rnd_dst)
                svf2p_pkg::R_T:  r_t  <= rnd_val;
                svf2p_pkg::R_GH: r_gh <= rnd_val;
                svf2p_pkg::R_GB: r_gb <= rnd_val;
                default: ;
            endcase
        end
        case (i_uop.alu_dst)
            svf2p_pkg::D_T:   r_t   <= alu_sum[TW-1:0];
            svf2p_pkg::D_HPF: r_hpf <= alu_sat;
            svf2p_pkg::D_BPF: r_bpf <= alu_sat;
            svf2p_pkg::D_LPF: r_lpf <= alu_sat;
            svf2p_pkg::D_BSF: r_bsf <= alu_sat;
            default: ;
        endcase
    end

    // integrator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z1 <= '0;
            r_z2 <= '0;
        end else begin
            if (i_uop.alu_dst == svf2p_pkg::D_Z1) begin
                r_z1 <= alu_sat;
            end
            if (i_uop.alu_dst == svf2p_pkg::D_Z2) begin
                r_z2 <= alu_sat;
            end
        end
    end

    // ---------------- output select and clamp ----------------
    always_comb begin
        if (r_ftype[svf2p_pkg::FT_BYPASS_BIT]) begin
            y_src = SW'(r_x);
        end else begin
            case (r_ftype)
                svf2p_pkg::FT_LPF: y_src = r_lpf;
                svf2p_pkg::FT_HPF: y_src = r_hpf;
                svf2p_pkg::FT_BPF: y_src = r_bpf;
                default:           y_src = r_bsf;
            endcase
        end
        if (y_src > Y_MAX) begin
            o_y    = Y_MAX[SB-1:0];
            o_clip = 1'b1;
        end else if (y_src < Y_MIN) begin
            o_y    = Y_MIN[SB-1:0];
            o_clip = 1'b1;
        end else begin
            o_y    = y_src[SB-1:0];
            o_clip = 1'b0;
        end
    end

    assign o_stat.bypass = r_ftype[svf2p_pkg::FT_BYPASS_BIT];
    assign o_stat.blend  = (r_ftype == svf2p_pkg::FT_BSF);

endmodule

`default_nettype wire
